FILE: design/ltc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lexer token classifier.
// No dependencies; every other design file refers to this package.
package ltc_pkg;

   // Character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Keyword table; byte i of a keyword sits at bits [8*i +: 8]
   localparam int KW_COUNT  = 8;
   localparam int KW_MAXLEN = 6;

   localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_0074_6E69,   // int
      48'h0000_7261_6863,   // char
      48'h0074_616F_6C66,   // float
      48'h6674_6E69_7270,   // printf
      48'h0000_0072_6F66,   // for
      48'h0065_6C69_6877,   // while
      48'h0000_0000_6669,   // if
      48'h0000_6573_6C65    // else
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd4, 3'd5, 3'd6, 3'd3, 3'd5, 3'd2, 3'd4
   };

   localparam int OUT_W = 32;

   typedef enum logic [2:0] {
      KIND_TOKEN         = 3'd0,
      KIND_OPERATOR      = 3'd1,
      KIND_DELIMITER     = 3'd2,
      KIND_KEYWORD       = 3'd3,
      KIND_IDENT         = 3'd4,
      KIND_BLANK         = 3'd5,
      KIND_COMMENT_START = 3'd6,
      KIND_IN_COMMENT    = 3'd7
   } ltc_kind_type;

   typedef struct packed {
      ltc_kind_type     kind;
      logic [OUT_W-1:0] operators_seen;
      logic [OUT_W-1:0] delimiters_seen;
      logic [OUT_W-1:0] keywords_seen;
      logic [OUT_W-1:0] comments_seen;
      logic             last;
   } ltc_result_type;

   // Results produced by one byte: count is 0, 1 or 2, first goes out first
   typedef struct packed {
      logic [1:0]     count;
      ltc_result_type first;
      ltc_result_type second;
   } ltc_push_type;

   localparam int FIFO_DEPTH      = 8;
   localparam int FIFO_PTR_W      = 3;
   localparam int FIFO_LEVEL_W    = 4;
   // room for the byte in flight plus the new one, two results each
   localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 4;

   typedef struct packed {
      logic [FIFO_LEVEL_W-1:0] level;
      logic                    has_room;
   } ltc_fifo_status_type;

endpackage

FILE: design/ltc_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on ltc_pkg for field widths.
interface ltc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ltc_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [2:0]               kind;
   logic [ltc_pkg::OUT_W-1:0] operators_seen;
   logic [ltc_pkg::OUT_W-1:0] delimiters_seen;
   logic [ltc_pkg::OUT_W-1:0] keywords_seen;
   logic [ltc_pkg::OUT_W-1:0] comments_seen;
   logic                     last;
   modport source (output valid, output kind, output operators_seen, output delimiters_seen,
                   output keywords_seen, output comments_seen, output last, input ready);
   modport sink   (input valid, input kind, input operators_seen, input delimiters_seen,
                   input keywords_seen, input comments_seen, input last, output ready);
endinterface

FILE: design/lexer_token_classifier_core.sv
`timescale 1ns / 1ps
// Lexer token classifier: one source byte per cycle in while ready, classified results out.
// Accepted bytes are registered, then scanned; results are written to the result queue.
// Throughput: one byte per cycle while ready is high; a byte's two results leave one
// at a time, absorbed by the eight-entry result queue, whose free space gates req_bus.ready.
// Reset (synchronous): clears line/comment state, token length, counters and the queue.
module lexer_token_classifier_core #(
   parameter int COUNT_WIDTH = 32,
   parameter int TOKEN_KEEP  = 6
) (
   input  logic             clock,
   input  logic             reset,
   ltc_req_if.sink          req_bus,
   ltc_rsp_if.source        rsp_bus
);

   logic                         in_valid_ff, in_valid_in;
   logic [7:0]                   in_ch_ff, in_ch_in;
   logic                         req_accept;
   ltc_pkg::ltc_push_type        push;
   ltc_pkg::ltc_result_type      out_data;
   ltc_pkg::ltc_fifo_status_type fifo_status;
   logic                         out_valid;

   assign req_bus.ready = fifo_status.has_room;
   assign req_accept    = req_bus.valid & req_bus.ready;
   assign in_valid_in   = req_accept;
   assign in_ch_in      = req_bus.ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ch_ff <= in_ch_in;
      end
   end

   ltc_scan #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TOKEN_KEEP  (TOKEN_KEEP)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_ch    (in_ch_ff),
      .push     (push)
   );

   ltc_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .status    (fifo_status)
   );

   assign rsp_bus.valid           = out_valid;
   assign rsp_bus.kind            = out_data.kind;
   assign rsp_bus.operators_seen  = out_data.operators_seen;
   assign rsp_bus.delimiters_seen = out_data.delimiters_seen;
   assign rsp_bus.keywords_seen   = out_data.keywords_seen;
   assign rsp_bus.comments_seen   = out_data.comments_seen;
   assign rsp_bus.last            = out_data.last;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= ltc_pkg::FIFO_LEVEL_W'(ltc_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("scanner pushed more than two results");

   a_push_needs_byte: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> in_valid_ff)
      else $error("result pushed without a byte in flight");

   a_byte_from_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted byte did not reach the scanner");

endmodule

FILE: design/ltc_scan.sv
`timescale 1ns / 1ps
// Per-byte scanner: token buffer, line/comment state, saturating counters.
// Depends on ltc_pkg; produces up to two results per byte.
module ltc_scan #(
   parameter int COUNT_WIDTH = 32,
   parameter int TOKEN_KEEP  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_ch,
   output ltc_pkg::ltc_push_type push
);

   localparam int LEN_W = $clog2(TOKEN_KEEP + 2);
   localparam int IDX_W = $clog2(TOKEN_KEEP);

   logic [7:0]             tok_chars_ff [TOKEN_KEEP];
   logic [LEN_W-1:0]       tok_len_ff, tok_len_in;
   logic                   line_start_ff, line_start_in;
   logic                   slash_ff, slash_in;
   logic                   comment_ff, comment_in;
   logic [COUNT_WIDTH-1:0] op_ff, op_in;
   logic [COUNT_WIDTH-1:0] del_ff, del_in;
   logic [COUNT_WIDTH-1:0] kw_ff, kw_in;
   logic [COUNT_WIDTH-1:0] cmt_ff, cmt_in;

   logic                   kw_hit;
   logic                   tok_wr;
   logic                   classify_en;
   logic [COUNT_WIDTH-1:0] op_inc, op_base, op_base_inc, del_inc, kw_inc, cmt_inc;
   ltc_pkg::ltc_kind_type  cls_kind;
   logic [COUNT_WIDTH-1:0] cls_op, cls_del, cls_kw;
   logic [LEN_W-1:0]       cls_len;
   logic                   cls_wr;
   logic                   is_op, is_delim, is_blank;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic ltc_pkg::ltc_result_type make_result(
      input ltc_pkg::ltc_kind_type  kind,
      input logic [COUNT_WIDTH-1:0] op,
      input logic [COUNT_WIDTH-1:0] del,
      input logic [COUNT_WIDTH-1:0] kw,
      input logic [COUNT_WIDTH-1:0] cmt,
      input logic                   last
   );
      ltc_pkg::ltc_result_type r;
      r.kind            = kind;
      r.operators_seen  = ltc_pkg::OUT_W'(op);
      r.delimiters_seen = ltc_pkg::OUT_W'(del);
      r.keywords_seen   = ltc_pkg::OUT_W'(kw);
      r.comments_seen   = ltc_pkg::OUT_W'(cmt);
      r.last            = last;
      return r;
   endfunction

   assign is_op = (in_ch == ltc_pkg::CH_PLUS) || (in_ch == ltc_pkg::CH_MINUS) ||
                  (in_ch == ltc_pkg::CH_STAR) || (in_ch == ltc_pkg::CH_SLASH) ||
                  (in_ch == ltc_pkg::CH_PERCENT);
   assign is_delim = (in_ch == ltc_pkg::CH_LBRACE) || (in_ch == ltc_pkg::CH_RBRACE) ||
                     (in_ch == ltc_pkg::CH_LBRACK) || (in_ch == ltc_pkg::CH_RBRACK) ||
                     (in_ch == ltc_pkg::CH_COMMA)  || (in_ch == ltc_pkg::CH_DQUOTE) ||
                     (in_ch == ltc_pkg::CH_COLON)  || (in_ch == ltc_pkg::CH_SEMI)   ||
                     (in_ch == ltc_pkg::CH_LPAREN) || (in_ch == ltc_pkg::CH_RPAREN);
   assign is_blank = (in_ch == ltc_pkg::CH_SPACE) || (in_ch == ltc_pkg::CH_NEWLINE);

   assign op_inc      = sat_inc(op_ff);
   // a held slash is counted before the byte after it
   assign op_base     = slash_ff ? op_inc : op_ff;
   assign op_base_inc = sat_inc(op_base);
   assign del_inc     = sat_inc(del_ff);
   assign kw_inc      = sat_inc(kw_ff);
   assign cmt_inc     = sat_inc(cmt_ff);

   // Keyword match against the stored token bytes
   always_comb begin
      logic match;
      kw_hit = 1'b0;
      for (int k = 0; k < ltc_pkg::KW_COUNT; k++) begin
         match = (tok_len_ff == LEN_W'(ltc_pkg::KW_LEN[k]));
         for (int i = 0; i < ltc_pkg::KW_MAXLEN; i++) begin
            if ((3'(i) < ltc_pkg::KW_LEN[k]) &&
                (tok_chars_ff[i] != ltc_pkg::KW_TEXT[k][8*i +: 8])) begin
               match = 1'b0;
            end
         end
         kw_hit = kw_hit | match;
      end
   end

   // Ordinary classification of a byte outside a comment
   always_comb begin
      cls_kind = ltc_pkg::KIND_TOKEN;
      cls_op   = op_base;
      cls_del  = del_ff;
      cls_kw   = kw_ff;
      cls_len  = tok_len_ff;
      cls_wr   = 1'b0;
      if (is_delim) begin
         cls_kind = ltc_pkg::KIND_DELIMITER;
         cls_del  = del_inc;
      end else if (is_op) begin
         cls_kind = ltc_pkg::KIND_OPERATOR;
         cls_op   = op_base_inc;
      end else if (is_blank) begin
         if (tok_len_ff != '0) begin
            if (kw_hit) begin
               cls_kind = ltc_pkg::KIND_KEYWORD;
               cls_kw   = kw_inc;
            end else begin
               cls_kind = ltc_pkg::KIND_IDENT;
            end
            cls_len = '0;
         end else begin
            cls_kind = ltc_pkg::KIND_BLANK;
         end
      end else begin
         cls_wr = (tok_len_ff < LEN_W'(TOKEN_KEEP));
         if (tok_len_ff <= LEN_W'(TOKEN_KEEP)) begin
            cls_len = tok_len_ff + LEN_W'(1);
         end
      end
   end

   always_comb begin
      tok_len_in    = tok_len_ff;
      line_start_in = line_start_ff;
      slash_in      = slash_ff;
      comment_in    = comment_ff;
      op_in         = op_ff;
      del_in        = del_ff;
      kw_in         = kw_ff;
      cmt_in        = cmt_ff;
      classify_en   = 1'b0;
      push.count    = 2'd0;
      push.first    = make_result(ltc_pkg::KIND_IN_COMMENT, op_ff, del_ff, kw_ff, cmt_ff, 1'b1);
      push.second   = push.first;
      if (in_valid) begin
         if (comment_ff) begin
            if (in_ch == ltc_pkg::CH_NEWLINE) begin
               comment_in    = 1'b0;
               line_start_in = 1'b1;
            end
            push.count = 2'd1;
         end else if (slash_ff) begin
            slash_in = 1'b0;
            if (in_ch == ltc_pkg::CH_SLASH) begin
               comment_in = 1'b1;
               cmt_in     = cmt_inc;
               push.count = 2'd1;
               push.first = make_result(ltc_pkg::KIND_COMMENT_START, op_ff, del_ff, kw_ff,
                                        cmt_inc, 1'b1);
            end else begin
               classify_en = 1'b1;
               push.count  = 2'd2;
               push.first  = make_result(ltc_pkg::KIND_OPERATOR, op_inc, del_ff, kw_ff,
                                         cmt_ff, 1'b0);
               push.second = make_result(cls_kind, cls_op, cls_del, cls_kw, cmt_ff, 1'b1);
            end
         end else if (line_start_ff && (in_ch == ltc_pkg::CH_SLASH)) begin
            // hold a leading slash until the next byte decides
            line_start_in = 1'b0;
            slash_in      = 1'b1;
         end else begin
            classify_en = 1'b1;
            push.count  = 2'd1;
            push.first  = make_result(cls_kind, cls_op, cls_del, cls_kw, cmt_ff, 1'b1);
         end
      end
      if (classify_en) begin
         line_start_in = (in_ch == ltc_pkg::CH_NEWLINE);
         op_in         = cls_op;
         del_in        = cls_del;
         kw_in         = cls_kw;
         tok_len_in    = cls_len;
      end
   end

   assign tok_wr = classify_en & cls_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_len_ff    <= '0;
         line_start_ff <= 1'b1;
         slash_ff      <= 1'b0;
         comment_ff    <= 1'b0;
         op_ff         <= '0;
         del_ff        <= '0;
         kw_ff         <= '0;
         cmt_ff        <= '0;
      end else begin
         tok_len_ff    <= tok_len_in;
         line_start_ff <= line_start_in;
         slash_ff      <= slash_in;
         comment_ff    <= comment_in;
         op_ff         <= op_in;
         del_ff        <= del_in;
         kw_ff         <= kw_in;
         cmt_ff        <= cmt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_wr) begin
         tok_chars_ff[tok_len_ff[IDX_W-1:0]] <= in_ch;
      end
   end

endmodule

FILE: design/ltc_result_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one.
// Depends on ltc_pkg for the result and status types.
module ltc_result_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  ltc_pkg::ltc_push_type        push,
   input  logic                         out_ready,
   output logic                         out_valid,
   output ltc_pkg::ltc_result_type      out_data,
   output ltc_pkg::ltc_fifo_status_type status
);

   localparam int PTR_W   = ltc_pkg::FIFO_PTR_W;
   localparam int LEVEL_W = ltc_pkg::FIFO_LEVEL_W;

   ltc_pkg::ltc_result_type mem_ff [ltc_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic                    pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign level_in  = level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);

   assign status.level    = level_ff;
   assign status.has_room = (level_ff <= LEVEL_W'(ltc_pkg::FIFO_ACCEPT_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

FILE: tb/sv/tb_lexer_token_classifier_core.sv
`timescale 1ns / 1ps
// Self-checking bench for lexer_token_classifier_core: streams source text bytes in,
// predicts every classified result and compares it as it leaves the block.
// Depends on ltc_pkg and the ltc_req_if / ltc_rsp_if channel interfaces.
module tb_lexer_token_classifier_core;

   localparam int COUNT_WIDTH  = 32;
   localparam int TOKEN_KEEP   = 6;
   localparam int TEXT_BYTES   = 1950;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [7:0] OP_CHARS [5] = '{
      ltc_pkg::CH_PLUS, ltc_pkg::CH_MINUS, ltc_pkg::CH_STAR, ltc_pkg::CH_SLASH,
      ltc_pkg::CH_PERCENT
   };
   localparam logic [7:0] DELIM_CHARS [10] = '{
      ltc_pkg::CH_LBRACE, ltc_pkg::CH_RBRACE, ltc_pkg::CH_LBRACK, ltc_pkg::CH_RBRACK,
      ltc_pkg::CH_COMMA, ltc_pkg::CH_DQUOTE, ltc_pkg::CH_COLON, ltc_pkg::CH_SEMI,
      ltc_pkg::CH_LPAREN, ltc_pkg::CH_RPAREN
   };

   string keyword_text [8] = '{"int", "char", "float", "printf", "for", "while", "if", "else"};

   logic clock;
   logic reset;
   int unsigned cycle_count = 0;
   int unsigned chars_sent = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   logic [7:0] text_q [$];

   ltc_req_if req_bus ();
   ltc_rsp_if rsp_bus ();

   lexer_token_classifier_core #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TOKEN_KEEP  (TOKEN_KEEP)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   function automatic bit is_op(logic [7:0] c);
      return c inside {ltc_pkg::CH_PLUS, ltc_pkg::CH_MINUS, ltc_pkg::CH_STAR,
                       ltc_pkg::CH_SLASH, ltc_pkg::CH_PERCENT};
   endfunction

   function automatic bit is_delim(logic [7:0] c);
      return c inside {ltc_pkg::CH_LBRACE, ltc_pkg::CH_RBRACE, ltc_pkg::CH_LBRACK,
                       ltc_pkg::CH_RBRACK, ltc_pkg::CH_COMMA, ltc_pkg::CH_DQUOTE,
                       ltc_pkg::CH_COLON, ltc_pkg::CH_SEMI, ltc_pkg::CH_LPAREN,
                       ltc_pkg::CH_RPAREN};
   endfunction

   // Shadow of the lexer state plus the queue of results still owed by the block
   class token_tally_model;
      logic [7:0]                word_bytes [TOKEN_KEEP];
      int unsigned               word_len;
      bit                        line_start;
      bit                        slash_held;
      bit                        skipping;
      logic [ltc_pkg::OUT_W-1:0] op_cnt;
      logic [ltc_pkg::OUT_W-1:0] delim_cnt;
      logic [ltc_pkg::OUT_W-1:0] kw_cnt;
      logic [ltc_pkg::OUT_W-1:0] cmt_cnt;
      ltc_pkg::ltc_result_type   expected_q [$];
      int unsigned               errors;
      int unsigned               bytes_taken;
      int unsigned               results_checked;
      int unsigned               kind_hits [8];

      function new();
         word_len = 0;
         line_start = 1'b1;
         slash_held = 1'b0;
         skipping = 1'b0;
         op_cnt = '0;
         delim_cnt = '0;
         kw_cnt = '0;
         cmt_cnt = '0;
         errors = 0;
         bytes_taken = 0;
         results_checked = 0;
         foreach (kind_hits[i]) kind_hits[i] = 0;
      endfunction

      // Hold at all ones once full
      function logic [ltc_pkg::OUT_W-1:0] bump(logic [ltc_pkg::OUT_W-1:0] v);
         return (v == {ltc_pkg::OUT_W{1'b1}}) ? v : v + 1'b1;
      endfunction

      function void push(ltc_pkg::ltc_kind_type k, logic fin);
         ltc_pkg::ltc_result_type r;
         r.kind = k;
         r.operators_seen = op_cnt;
         r.delimiters_seen = delim_cnt;
         r.keywords_seen = kw_cnt;
         r.comments_seen = cmt_cnt;
         r.last = fin;
         expected_q.push_back(r);
      endfunction

      function bit word_is_keyword();
         bit same;
         foreach (keyword_text[k]) begin
            if (keyword_text[k].len() == word_len) begin
               same = 1'b1;
               for (int i = 0; i < word_len; i++) begin
                  if (word_bytes[i] != keyword_text[k][i]) same = 1'b0;
               end
               if (same) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function ltc_pkg::ltc_kind_type sort_byte(logic [7:0] c);
         bit kw;
         line_start = (c == ltc_pkg::CH_NEWLINE);
         if (is_delim(c)) begin
            delim_cnt = bump(delim_cnt);
            return ltc_pkg::KIND_DELIMITER;
         end
         if (is_op(c)) begin
            op_cnt = bump(op_cnt);
            return ltc_pkg::KIND_OPERATOR;
         end
         if (c == ltc_pkg::CH_SPACE || c == ltc_pkg::CH_NEWLINE) begin
            if (word_len == 0) return ltc_pkg::KIND_BLANK;
            kw = word_is_keyword();
            word_len = 0;
            if (kw) begin
               kw_cnt = bump(kw_cnt);
               return ltc_pkg::KIND_KEYWORD;
            end
            return ltc_pkg::KIND_IDENT;
         end
         // Keep only the first bytes; the length sticks one past the store
         if (word_len < TOKEN_KEEP) word_bytes[word_len] = c;
         if (word_len <= TOKEN_KEEP) word_len++;
         return ltc_pkg::KIND_TOKEN;
      endfunction

      function void take_byte(logic [7:0] c);
         bytes_taken++;
         if (skipping) begin
            if (c == ltc_pkg::CH_NEWLINE) begin
               skipping = 1'b0;
               line_start = 1'b1;
            end
            push(ltc_pkg::KIND_IN_COMMENT, 1'b1);
            return;
         end
         if (slash_held) begin
            slash_held = 1'b0;
            if (c == ltc_pkg::CH_SLASH) begin
               skipping = 1'b1;
               cmt_cnt = bump(cmt_cnt);
               push(ltc_pkg::KIND_COMMENT_START, 1'b1);
               return;
            end
            // Release the held slash as an operator, then the byte itself
            op_cnt = bump(op_cnt);
            push(ltc_pkg::KIND_OPERATOR, 1'b0);
            push(sort_byte(c), 1'b1);
            return;
         end
         if (line_start && c == ltc_pkg::CH_SLASH) begin
            line_start = 1'b0;
            slash_held = 1'b1;
            return;
         end
         push(sort_byte(c), 1'b1);
      endfunction

      function void field_check(string name, logic [ltc_pkg::OUT_W-1:0] want,
                                logic [ltc_pkg::OUT_W-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 30)
               $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                        $time, results_checked, name, want, got);
         end
      endfunction

      function void match_result(ltc_pkg::ltc_result_type got);
         ltc_pkg::ltc_result_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, got.kind);
            return;
         end
         want = expected_q.pop_front();
         kind_hits[want.kind]++;
         field_check("kind", ltc_pkg::OUT_W'(want.kind), ltc_pkg::OUT_W'(got.kind));
         field_check("operators_seen", want.operators_seen, got.operators_seen);
         field_check("delimiters_seen", want.delimiters_seen, got.delimiters_seen);
         field_check("keywords_seen", want.keywords_seen, got.keywords_seen);
         field_check("comments_seen", want.comments_seen, got.comments_seen);
         field_check("last", ltc_pkg::OUT_W'(want.last), ltc_pkg::OUT_W'(got.last));
      endfunction
   endclass

   token_tally_model model = new();

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, model.expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) model.take_byte(req_bus.ch);
   end

   always @(posedge clock) begin
      ltc_pkg::ltc_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind = ltc_pkg::ltc_kind_type'(rsp_bus.kind);
         got.operators_seen = rsp_bus.operators_seen;
         got.delimiters_seen = rsp_bus.delimiters_seen;
         got.keywords_seen = rsp_bus.keywords_seen;
         got.comments_seen = rsp_bus.comments_seen;
         got.last = rsp_bus.last;
         model.match_result(got);
      end
   end

   // Result side: while receiver_stalls is set, stall a random number of cycles before taking each transaction
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_stalls ? $urandom_range(0, 18) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_char(input logic [7:0] c);
      int unsigned gap;
      gap = sender_gaps ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch <= c;
      do @(posedge clock); while (!req_bus.ready);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   function automatic logic [7:0] word_char();
      string letters = "abcefhilnoprstw";
      logic [7:0] c;
      // Mostly keyword letters so near misses show up often
      if ($urandom_range(0, 9) < 6) return letters[$urandom_range(0, letters.len() - 1)];
      do c = 8'($urandom_range(0, 255));
      while (is_op(c) || is_delim(c) || c == ltc_pkg::CH_SPACE || c == ltc_pkg::CH_NEWLINE);
      return c;
   endfunction

   function automatic void build_line();
      int unsigned pick;
      int unsigned n;
      string kw;
      logic [7:0] c;
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         text_q.push_back(ltc_pkg::CH_SLASH);
         text_q.push_back(ltc_pkg::CH_SLASH);
         repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(0, 255));
            if (c == ltc_pkg::CH_NEWLINE) c = ltc_pkg::CH_SLASH;
            text_q.push_back(c);
         end
         text_q.push_back(ltc_pkg::CH_NEWLINE);
         return;
      end
      if (pick < 20) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      // Leading slash, usually not followed by a second one
      if (pick < 28) text_q.push_back(ltc_pkg::CH_SLASH);
      repeat ($urandom_range(0, 7)) begin
         kw = keyword_text[$urandom_range(0, 7)];
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               foreach (kw[i]) text_q.push_back(kw[i]);
            end
            4, 5: begin
               repeat ($urandom_range(1, 9)) text_q.push_back(word_char());
            end
            6: begin
               text_q.push_back(OP_CHARS[$urandom_range(0, 4)]);
            end
            7: begin
               text_q.push_back(DELIM_CHARS[$urandom_range(0, 9)]);
            end
            8: begin
               foreach (kw[i]) text_q.push_back(kw[i]);
               if ($urandom_range(0, 1) != 0) text_q.push_back(OP_CHARS[$urandom_range(0, 4)]);
               else text_q.push_back(DELIM_CHARS[$urandom_range(0, 9)]);
            end
            default: begin
               if ($urandom_range(0, 1) != 0) kw = kw.substr(0, kw.len() - 2);
               foreach (kw[i]) text_q.push_back(kw[i]);
               if ($urandom_range(0, 1) != 0) text_q.push_back(word_char());
            end
         endcase
         n = $urandom_range(0, 9);
         if (n < 7) begin
            text_q.push_back(ltc_pkg::CH_SPACE);
         end else if (n == 7) begin
            text_q.push_back(ltc_pkg::CH_SPACE);
            text_q.push_back(ltc_pkg::CH_SPACE);
         end
      end
      text_q.push_back(ltc_pkg::CH_NEWLINE);
   endfunction

   initial begin
      int unsigned phase;
      int unsigned next_switch;
      bit drained;
      bit failed;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.ch <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Keyword, comment line, held slash released, operators, delimiters, blank,
      // overlong token, slash before newline, extreme byte values
      send_text("int\n//a\n/+-*%{\"; printfx \n/\n");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(ltc_pkg::CH_SPACE);

      phase = 0;
      next_switch = chars_sent;
      drained = 1'b0;
      while (chars_sent < TEXT_BYTES) begin
         if (chars_sent >= next_switch) begin
            sender_gaps = (phase % 4 == 0) || (phase % 4 == 2);
            receiver_stalls = (phase % 4 == 0) || (phase % 4 == 3);
            phase++;
            next_switch += 250;
         end
         if (!drained && chars_sent >= TEXT_BYTES / 2) begin
            // Hold off until the block has delivered everything owed
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (model.expected_q.size() != 0) @(posedge clock);
            drained = 1'b1;
         end
         build_line();
         foreach (text_q[i]) send_char(text_q[i]);
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (model.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      failed = (model.errors != 0) || (model.expected_q.size() != 0);
      $display("Streamed %0d text bytes, checked %0d results, %0d mismatches",
               model.bytes_taken, model.results_checked, model.errors);
      $display("Kinds: token %0d op %0d delim %0d keyword %0d ident %0d blank %0d comment %0d/%0d",
               model.kind_hits[ltc_pkg::KIND_TOKEN], model.kind_hits[ltc_pkg::KIND_OPERATOR],
               model.kind_hits[ltc_pkg::KIND_DELIMITER], model.kind_hits[ltc_pkg::KIND_KEYWORD],
               model.kind_hits[ltc_pkg::KIND_IDENT], model.kind_hits[ltc_pkg::KIND_BLANK],
               model.kind_hits[ltc_pkg::KIND_COMMENT_START],
               model.kind_hits[ltc_pkg::KIND_IN_COMMENT]);
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
